// File: rtl/trq_pkg.sv
// Shared types and constants for the toolpath ribbon quad builder.
package trq_pkg;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_LAYER  = 2'd1;
  localparam logic [1:0] KIND_CHUNK  = 2'd2;

  localparam logic CFG_CHUNK_LAYERS = 1'b0;
  localparam logic CFG_FALLBACK_HW  = 1'b1;

  localparam logic [2:0] COLOR_OTHER = 3'd4;

  typedef enum logic [1:0] {
    OP_SEG   = 2'd0,
    OP_POINT = 2'd1,
    OP_MARK  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic [29:0]        hw;
    logic [2:0]         color;
    logic               last_layer;
  } entry_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic [2:0]         color_class;
    logic [31:0]        offset;
    logic [31:0]        count;
    logic               last;
  } res_t;

endpackage

// File: rtl/trq_if.sv
// Channel interfaces: toolpath items in, geometry results out.
interface trq_seg_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic [30:0]        width;
  logic [2:0]         move_type;
  logic               extruding;
  logic               last_layer;
  modport source (output valid, func, start_x, start_y, start_z, end_x, end_y, end_z,
                  width, move_type, extruding, last_layer, input ready);
  modport sink (input valid, func, start_x, start_y, start_z, end_x, end_y, end_z,
                width, move_type, extruding, last_layer, output ready);
endinterface

interface trq_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic [2:0]         color_class;
  logic [31:0]        offset;
  logic [31:0]        count;
  logic               last;
  modport source (output valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, color_class, offset,
                  count, last, input ready);
  modport sink (input valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, color_class, offset,
                count, last, output ready);
endinterface

// File: rtl/trq_front.sv
// Front end: accepts items, drops travel moves, classifies and packs queue entries.
module trq_front #(
  parameter int COORD_WIDTH = 32
) (
  trq_seg_if.sink         seg,
  input  logic [15:0]     fallback_half_width,
  input  logic            q_full,
  output logic            q_push,
  output trq_pkg::entry_t q_data
);

  localparam int CWE = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
  localparam int SH  = 32 - CWE;

  function automatic logic signed [31:0] sext(input logic [31:0] v);
    logic signed [31:0] t;
    t = signed'(v << SH);
    return t >>> SH;
  endfunction

  logic signed [31:0] sx, sy, sz, ex, ey, ez;
  logic [29:0]        hw;
  logic               zero_len;

  assign seg.ready = !q_full;

  always_comb begin
    sx = sext(seg.start_x);
    sy = sext(seg.start_y);
    sz = sext(seg.start_z);
    ex = sext(seg.end_x);
    ey = sext(seg.end_y);
    ez = sext(seg.end_z);
    hw = seg.width[30:1];
    if (hw == '0) hw = {14'd0, fallback_half_width};
    zero_len = (sx == ex) && (sy == ey) && (sz == ez);

    q_data.sx         = sx;
    q_data.sy         = sy;
    q_data.sz         = sz;
    q_data.ex         = ex;
    q_data.ey         = ey;
    q_data.ez         = ez;
    q_data.hw         = hw;
    q_data.color      = (seg.move_type > trq_pkg::COLOR_OTHER) ? trq_pkg::COLOR_OTHER
                                                               : seg.move_type;
    q_data.last_layer = seg.last_layer;
    if (seg.func) q_data.op = trq_pkg::OP_MARK;
    else if (zero_len) q_data.op = trq_pkg::OP_POINT;
    else q_data.op = trq_pkg::OP_SEG;

    q_push = seg.valid && !q_full && (seg.func || seg.extruding);
  end

endmodule

// File: rtl/trq_fifo.sv
// Two-entry queue between front and back end.
module trq_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  trq_pkg::entry_t wr_data,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output trq_pkg::entry_t rd_data
);

  trq_pkg::entry_t mem [2];
  logic            wp, rp;
  logic [1:0]      cnt;
  logic            do_push, do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign rd_data = mem[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop) rp <= !rp;
      unique case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// File: rtl/trq_back.sv
// Back end: box tracking, direction normalize, sqrt, divides and result beats.
module trq_back #(
  parameter int COORD_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  trq_pkg::entry_t q_data,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic [10:0]     chunk_layers,
  trq_res_if.source       res
);

  localparam int CWE = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
  localparam logic signed [33:0] CMAX = (34'sd1 <<< (CWE - 1)) - 34'sd1;
  localparam logic signed [33:0] CMIN = -CMAX - 34'sd1;

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > CMAX) return CMAX[31:0];
    else if (v < CMIN) return CMIN[31:0];
    else return v[31:0];
  endfunction

  function automatic logic signed [33:0] ext(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return (a > b) ? a : b;
  endfunction

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_SQ, S_SQRT, S_MUL, S_DIV, S_EMIT, S_MARK
  } state_t;

  state_t             state;
  logic signed [31:0] sx, sy, sz, ex, ey, ez;
  logic [29:0]        hw;
  logic [2:0]         color;
  logic               neg_ox, neg_oy;
  logic [32:0]        ux, uy, uz;
  logic [59:0]        prod;
  logic [61:0]        acc;
  logic [61:0]        sreg;
  logic [32:0]        srem;
  logic [30:0]        rt;
  logic [32:0]        drem;
  logic [31:0]        dnum;
  logic [31:0]        quo;
  logic [31:0]        ox_mag, oy_mag;
  logic               sel_y;
  logic [4:0]         cnt;
  logic [1:0]         beat;
  logic               close;
  logic signed [31:0] box_min_x, box_min_y, box_min_z;
  logic signed [31:0] box_max_x, box_max_y, box_max_z;
  logic               geo;
  logic [31:0]        vertex_total, index_total, chunk_start;
  logic [9:0]         layers_in_chunk;
  logic               ov;
  trq_pkg::res_t      od;

  // combinational helpers
  logic               can_out;
  logic               emit;
  logic signed [32:0] dx, dy, dz;
  logic [32:0]        m;
  logic [29:0]        sq_op;
  logic [32:0]        srem_sh, trial;
  logic [32:0]        drem_sh;
  logic               dge;
  logic [60:0]        numer;
  logic [10:0]        lim, n_layers;
  logic signed [32:0] oxs, oys;
  logic signed [31:0] bx, by, bz;
  logic signed [33:0] vx, vy;
  logic               plus;

  assign can_out = !ov || res.ready;
  assign emit    = can_out && ((state == S_EMIT) || (state == S_MARK));
  assign q_pop   = (state == S_IDLE) && !q_empty;

  always_comb begin
    dx = {q_data.ex[31], q_data.ex} - {q_data.sx[31], q_data.sx};
    dy = {q_data.ey[31], q_data.ey} - {q_data.sy[31], q_data.sy};
    dz = {q_data.ez[31], q_data.ez} - {q_data.sz[31], q_data.sz};

    m = (ux > uy) ? ux : uy;
    if (uz > m) m = uz;

    unique case (cnt[1:0])
      2'd0:    sq_op = ux[29:0];
      2'd1:    sq_op = uy[29:0];
      default: sq_op = uz[29:0];
    endcase

    srem_sh = {srem[30:0], sreg[61:60]};
    trial   = {rt, 2'b01};

    drem_sh = {drem[31:0], dnum[31]};
    dge     = drem_sh >= {2'b00, rt};
    numer   = {1'b0, prod} + {31'd0, rt[30:1]};

    if (chunk_layers == 11'd0) lim = 11'd1;
    else if (chunk_layers > 11'd1024) lim = 11'd1024;
    else lim = chunk_layers;
    n_layers = {1'b0, layers_in_chunk} + 11'd1;

    oxs  = neg_ox ? -$signed({1'b0, ox_mag}) : $signed({1'b0, ox_mag});
    oys  = neg_oy ? -$signed({1'b0, oy_mag}) : $signed({1'b0, oy_mag});
    bx   = beat[1] ? ex : sx;
    by   = beat[1] ? ey : sy;
    bz   = beat[1] ? ez : sz;
    plus = (beat == 2'd1) || (beat == 2'd2);
    vx   = plus ? ext(bx) + {oxs[32], oxs} : ext(bx) - {oxs[32], oxs};
    vy   = plus ? ext(by) + {oys[32], oys} : ext(by) - {oys[32], oys};
  end

  assign res.valid       = ov;
  assign res.kind        = od.kind;
  assign res.a_x         = od.a_x;
  assign res.a_y         = od.a_y;
  assign res.a_z         = od.a_z;
  assign res.b_x         = od.b_x;
  assign res.b_y         = od.b_y;
  assign res.b_z         = od.b_z;
  assign res.color_class = od.color_class;
  assign res.offset      = od.offset;
  assign res.count       = od.count;
  assign res.last        = od.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ov              <= 1'b0;
      box_min_x       <= CMAX[31:0];
      box_min_y       <= CMAX[31:0];
      box_min_z       <= CMAX[31:0];
      box_max_x       <= CMIN[31:0];
      box_max_y       <= CMIN[31:0];
      box_max_z       <= CMIN[31:0];
      geo             <= 1'b0;
      vertex_total    <= '0;
      index_total     <= '0;
      chunk_start     <= '0;
      layers_in_chunk <= '0;
      cnt             <= '0;
      beat            <= '0;
      sel_y           <= 1'b0;
    end else begin
      if (ov && res.ready && !emit) ov <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            sx    <= q_data.sx;
            sy    <= q_data.sy;
            sz    <= q_data.sz;
            ex    <= q_data.ex;
            ey    <= q_data.ey;
            ez    <= q_data.ez;
            hw    <= q_data.hw;
            color <= q_data.color;
            beat  <= '0;
            if (q_data.op == trq_pkg::OP_MARK) begin
              close <= (n_layers >= lim) || q_data.last_layer;
              state <= S_MARK;
            end else begin
              box_min_x <= smin(box_min_x, smin(sat(ext(q_data.sx) - 34'(q_data.hw)),
                                                sat(ext(q_data.ex) - 34'(q_data.hw))));
              box_min_y <= smin(box_min_y, smin(sat(ext(q_data.sy) - 34'(q_data.hw)),
                                                sat(ext(q_data.ey) - 34'(q_data.hw))));
              box_min_z <= smin(box_min_z, smin(sat(ext(q_data.sz) - 34'(q_data.hw)),
                                                sat(ext(q_data.ez) - 34'(q_data.hw))));
              box_max_x <= smax(box_max_x, smax(sat(ext(q_data.sx) + 34'(q_data.hw)),
                                                sat(ext(q_data.ex) + 34'(q_data.hw))));
              box_max_y <= smax(box_max_y, smax(sat(ext(q_data.sy) + 34'(q_data.hw)),
                                                sat(ext(q_data.ey) + 34'(q_data.hw))));
              box_max_z <= smax(box_max_z, smax(sat(ext(q_data.sz) + 34'(q_data.hw)),
                                                sat(ext(q_data.ez) + 34'(q_data.hw))));
              geo <= 1'b1;
              if (q_data.op == trq_pkg::OP_SEG) begin
                ux     <= dx[32] ? 33'(-dx) : 33'(dx);
                uy     <= dy[32] ? 33'(-dy) : 33'(dy);
                uz     <= dz[32] ? 33'(-dz) : 33'(dz);
                neg_ox <= !dy[32] && (dy != '0);
                neg_oy <= dx[32];
                state  <= S_NORM;
              end
            end
          end
        end
        // scale so the largest magnitude lands in [2^29, 2^30)
        S_NORM: begin
          if (m[32:30] != '0) begin
            ux <= ux >> 1; uy <= uy >> 1; uz <= uz >> 1;
          end else if (m < 33'd2097152) begin
            ux <= ux << 8; uy <= uy << 8; uz <= uz << 8;
          end else if (m < 33'd33554432) begin
            ux <= ux << 4; uy <= uy << 4; uz <= uz << 4;
          end else if (m < 33'd134217728) begin
            ux <= ux << 2; uy <= uy << 2; uz <= uz << 2;
          end else if (m < 33'd536870912) begin
            ux <= ux << 1; uy <= uy << 1; uz <= uz << 1;
          end else begin
            cnt   <= '0;
            acc   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt[1:0] != 2'd3) prod <= sq_op * sq_op;
          if (cnt[1:0] != 2'd0) acc <= acc + {2'b00, prod};
          if (cnt[1:0] == 2'd3) begin
            sreg  <= acc + {2'b00, prod};
            srem  <= '0;
            rt    <= '0;
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_SQRT: begin
          sreg <= sreg << 2;
          if (srem_sh >= trial) begin
            srem <= srem_sh - trial;
            rt   <= {rt[29:0], 1'b1};
          end else begin
            srem <= srem_sh;
            rt   <= {rt[29:0], 1'b0};
          end
          if (cnt == 5'd30) begin
            cnt   <= '0;
            sel_y <= 1'b0;
            state <= S_MUL;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        // rt holds the length from here on
        S_MUL: begin
          if (cnt[0] == 1'b0) begin
            prod <= (sel_y ? ux[29:0] : uy[29:0]) * hw;
            cnt  <= 5'd1;
          end else begin
            drem  <= {4'd0, numer[60:32]};
            dnum  <= numer[31:0];
            quo   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          drem <= dge ? drem_sh - {2'b00, rt} : drem_sh;
          dnum <= dnum << 1;
          quo  <= {quo[30:0], dge};
          if (cnt == 5'd31) begin
            cnt <= '0;
            if (!sel_y) begin
              ox_mag <= {quo[30:0], dge};
              sel_y  <= 1'b1;
              state  <= S_MUL;
            end else begin
              oy_mag <= {quo[30:0], dge};
              beat   <= '0;
              state  <= S_EMIT;
            end
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_EMIT: begin
          if (can_out) begin
            ov             <= 1'b1;
            od.kind        <= trq_pkg::KIND_VERTEX;
            od.a_x         <= sat(vx);
            od.a_y         <= sat(vy);
            od.a_z         <= bz;
            od.b_x         <= '0;
            od.b_y         <= '0;
            od.b_z         <= '0;
            od.color_class <= color;
            od.offset      <= vertex_total + {30'd0, beat};
            od.count       <= '0;
            od.last        <= (beat == 2'd3);
            beat           <= beat + 2'd1;
            if (beat == 2'd3) begin
              vertex_total <= vertex_total + 32'd4;
              index_total  <= index_total + 32'd6;
              state        <= S_IDLE;
            end
          end
        end
        S_MARK: begin
          if (can_out) begin
            ov             <= 1'b1;
            od.color_class <= '0;
            od.b_x         <= (beat[0] && geo) ? box_max_x : '0;
            od.b_y         <= (beat[0] && geo) ? box_max_y : '0;
            od.b_z         <= (beat[0] && geo) ? box_max_z : '0;
            od.a_x         <= (beat[0] && geo) ? box_min_x : '0;
            od.a_y         <= (beat[0] && geo) ? box_min_y : '0;
            od.a_z         <= (beat[0] && geo) ? box_min_z : '0;
            if (!beat[0]) begin
              od.kind   <= trq_pkg::KIND_LAYER;
              od.offset <= '0;
              od.count  <= index_total;
              od.last   <= !close;
              beat      <= 2'd1;
              if (!close) begin
                layers_in_chunk <= n_layers[9:0];
                state           <= S_IDLE;
              end
            end else begin
              od.kind         <= trq_pkg::KIND_CHUNK;
              od.offset       <= chunk_start;
              od.count        <= index_total - chunk_start;
              od.last         <= 1'b1;
              chunk_start     <= index_total;
              layers_in_chunk <= '0;
              box_min_x       <= CMAX[31:0];
              box_min_y       <= CMAX[31:0];
              box_min_z       <= CMAX[31:0];
              box_max_x       <= CMIN[31:0];
              box_max_y       <= CMIN[31:0];
              box_max_z       <= CMIN[31:0];
              geo             <= 1'b0;
              state           <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/toolpath_ribbon_quad_builder_core.sv
// Segment: pop, normalize, squares, square root, two divides (x then y offset) and 4 vertex
// beats, plus output stalls; the serial math sets the rate.
// End-of-layer marker: layer record, then a chunk record when the chunk closes (limit or last layer).
// Travel moves are dropped at the input; a two-entry queue lets the input run ahead of the math.
// Reset (rst, synchronous, active high) clears counts and box, chunk_layers to 8 and
// fallback_half_width to 3277; no clearing pass.
module toolpath_ribbon_quad_builder_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  trq_seg_if.sink     seg,
  trq_res_if.source   res
);

  logic [10:0]     chunk_layers;
  logic [15:0]     fallback_half_width;
  logic            q_push, q_full;
  trq_pkg::entry_t push_data, pop_data;
  logic            q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_layers        <= 11'd8;
      fallback_half_width <= 16'd3277;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trq_pkg::CFG_CHUNK_LAYERS: chunk_layers        <= cfg_data[10:0];
        trq_pkg::CFG_FALLBACK_HW:  fallback_half_width <= cfg_data;
        default:                   chunk_layers        <= chunk_layers;
      endcase
    end
  end

  trq_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .seg                 (seg),
    .fallback_half_width (fallback_half_width),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_data              (push_data)
  );

  trq_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (push_data),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .rd_data (pop_data)
  );

  trq_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (pop_data),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .chunk_layers (chunk_layers),
    .res          (res)
  );

endmodule
